FILE: hdl/led_pkg.sv
// shared constants, codes and types of the edit distance unit
`default_nettype none

package led_pkg;

    localparam int MAX_LEN  = 64;
    localparam int CH_W     = 8;
    localparam int OP_W     = 2;
    localparam int DIST_W   = 7;
    localparam int DIST_MAX = (1 << DIST_W) - 1;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int COST_W   = $clog2(MAX_LEN + 2);
    localparam int SAT_W    = (COST_W > DIST_W) ? COST_W : DIST_W;

    typedef enum logic [OP_W-1:0] {
        OP_FIRST  = 2'd0,
        OP_SECOND = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   ch;
        logic [COST_W-1:0] left;
        logic [COST_W-1:0] diag;
    } token_t;

endpackage

`default_nettype wire

FILE: hdl/led_cell.sv
// one cell of the systolic row: one first-string char and its cost entry
`default_nettype none

module led_cell
    import led_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clear,
    input  wire logic              load_en,
    input  wire logic [CH_W-1:0]   load_ch,
    input  wire logic [COST_W-1:0] init_cost,
    input  wire token_t            tok_in,
    output token_t                 tok_out
);

    logic              loaded_reg;
    logic [CH_W-1:0]   char_reg;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic              tok_valid_reg;
    token_t            tok_reg;
    token_t            tok_next;

    logic [COST_W-1:0] up_cost;
    logic [COST_W-1:0] left_cost;
    logic [COST_W-1:0] sub_cost;
    logic [COST_W-1:0] min_a;

    always_comb begin
        up_cost   = cost_reg + COST_W'(1);
        left_cost = tok_in.left + COST_W'(1);
        sub_cost  = tok_in.diag + ((char_reg == tok_in.ch) ? COST_W'(0) : COST_W'(1));
        min_a     = (up_cost < left_cost) ? up_cost : left_cost;
        cost_next = (min_a < sub_cost) ? min_a : sub_cost;
    end

    always_comb begin
        tok_next = tok_in;
        if (loaded_reg) begin
            tok_next.left = cost_next;
            tok_next.diag = cost_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            loaded_reg <= 1'b0;
            cost_reg   <= init_cost;
        end else begin
            if (load_en) begin
                loaded_reg <= 1'b1;
            end
            if (tok_in.valid && loaded_reg) begin
                cost_reg <= cost_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            char_reg <= load_ch;
        end
        tok_reg <= tok_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    always_comb begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/levenshtein_edit_distance_unit.sv
// top level of the edit distance unit: control, systolic row and result register
//
//  channel  dir  ports                                       transfer when
//  s_       in   s_op, s_ch                                  s_valid && s_ready
//  m_       out  m_distance, m_overflow, m_order_error       m_valid && m_ready
//
// first- and second-string chars are taken one per cycle, ready stays high for them
// each second-string char walks the row of MAX_LEN cells, one cell per cycle
// a finish waits until every second-string char has left the row and the result
// register is free, then clears all state
// reset is synchronous, active low, and leaves every cost entry at its index plus one
`default_nettype none

module levenshtein_edit_distance_unit
    import led_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [OP_W-1:0]   s_op,
    input  wire logic [CH_W-1:0]   s_ch,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DIST_W-1:0]      m_distance,
    output logic                   m_overflow,
    output logic                   m_order_error
);

    logic [LEN_W-1:0]  first_len_reg,  first_len_next;
    logic [LEN_W-1:0]  second_cnt_reg, second_cnt_next;
    logic [LEN_W-1:0]  inflight_reg,   inflight_next;
    logic [COST_W-1:0] dist_reg,       dist_next;
    logic              ovf_reg,        ovf_next;
    logic              ord_reg,        ord_next;
    logic              m_valid_reg,    m_valid_next;
    logic [DIST_W-1:0] m_distance_reg;
    logic              m_overflow_reg;
    logic              m_order_error_reg;

    logic              s_xfer;
    logic              out_free;
    logic              load_en;
    logic              inject;
    logic              finish;
    logic              row_exit;
    logic [SAT_W-1:0]  dist_wide;
    logic [DIST_W-1:0] dist_sat;

    token_t tok [MAX_LEN+1];

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (s_op != OP_FINISH) || ((inflight_reg == '0) && out_free);
    assign s_xfer   = s_valid && s_ready;
    assign load_en  = s_xfer && (s_op == OP_FIRST) && (second_cnt_reg == '0)
                      && (first_len_reg < LEN_W'(MAX_LEN));
    assign inject   = s_xfer && (s_op == OP_SECOND) && (second_cnt_reg < LEN_W'(MAX_LEN));
    assign finish   = s_xfer && (s_op == OP_FINISH);
    assign row_exit = tok[MAX_LEN].valid;

    always_comb begin
        tok[0].valid = inject;
        tok[0].ch    = s_ch;
        tok[0].diag  = COST_W'(second_cnt_reg);
        tok[0].left  = COST_W'(second_cnt_reg) + COST_W'(1);
    end

    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        led_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (finish),
            .load_en   (load_en && (first_len_reg == LEN_W'(i))),
            .load_ch   (s_ch),
            .init_cost (COST_W'(i + 1)),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1])
        );
    end

    always_comb begin
        dist_wide = SAT_W'(dist_reg);
        dist_sat  = (dist_wide > SAT_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                   : DIST_W'(dist_wide);
    end

    always_comb begin
        first_len_next  = first_len_reg;
        second_cnt_next = second_cnt_reg;
        dist_next       = dist_reg;
        ovf_next        = ovf_reg;
        ord_next        = ord_reg;
        inflight_next   = inflight_reg + LEN_W'(inject) - LEN_W'(row_exit);
        m_valid_next    = m_valid_reg && !m_ready;

        if (row_exit) begin
            dist_next = tok[MAX_LEN].left;
        end

        if (s_xfer) begin
            case (s_op)
                OP_FIRST: begin
                    if (second_cnt_reg != '0) begin
                        ord_next = 1'b1;
                    end else if (first_len_reg >= LEN_W'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        first_len_next = first_len_reg + LEN_W'(1);
                        dist_next      = COST_W'(first_len_reg) + COST_W'(1);
                    end
                end
                OP_SECOND: begin
                    if (second_cnt_reg >= LEN_W'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        second_cnt_next = second_cnt_reg + LEN_W'(1);
                    end
                end
                OP_FINISH: begin
                    m_valid_next    = 1'b1;
                    first_len_next  = '0;
                    second_cnt_next = '0;
                    dist_next       = '0;
                    ovf_next        = 1'b0;
                    ord_next        = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_cnt_reg <= '0;
            inflight_reg   <= '0;
            dist_reg       <= '0;
            ovf_reg        <= 1'b0;
            ord_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            first_len_reg  <= first_len_next;
            second_cnt_reg <= second_cnt_next;
            inflight_reg   <= inflight_next;
            dist_reg       <= dist_next;
            ovf_reg        <= ovf_next;
            ord_reg        <= ord_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_distance_reg    <= dist_sat;
            m_overflow_reg    <= ovf_reg;
            m_order_error_reg <= ord_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_distance    = m_distance_reg;
    assign m_overflow    = m_overflow_reg;
    assign m_order_error = m_order_error_reg;

endmodule

`default_nettype wire

FILE: verif/levenshtein_edit_distance_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the edit distance unit: directed rows, random string pairs, stalls
module levenshtein_edit_distance_unit_tb
    import led_pkg::*;
();

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int ITEM_TARGET  = 2000;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = MAX_LEN + 16;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
        logic              order_error;
    } edit_result_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] ch;
        logic            typed;
        edit_result_t    res;
    } stim_row_t;

    localparam int N_ROWS = 19;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{OP_FINISH,   8'h00, 1'b1, '{7'd0, 1'b0, 1'b0}},
        '{OP_FIRST,    8'h00, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FIRST,    8'hFF, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'hFF, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'h00, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FINISH,   8'hFF, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FIRST,    8'h6B, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'h6B, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FIRST,    8'h78, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FINISH,   8'h55, 1'b1, '{7'd0, 1'b0, 1'b1}},
        '{OP_SECOND,   8'h01, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'h80, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'h7F, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FINISH,   8'hAA, 1'b1, '{7'd3, 1'b0, 1'b0}},
        '{OP_RESERVED, 8'hAA, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FIRST,    8'h61, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_RESERVED, 8'h55, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_SECOND,   8'h61, 1'b0, '{7'd0, 1'b0, 1'b0}},
        '{OP_FINISH,   8'h00, 1'b1, '{7'd0, 1'b0, 1'b0}}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_op;
    logic [CH_W-1:0]   s_ch;
    logic              m_valid;
    logic              m_ready;
    logic [DIST_W-1:0] m_distance;
    logic              m_overflow;
    logic              m_order_error;

    // predictor state
    logic [CH_W-1:0] a_chars [MAX_LEN];
    int              cost_col [MAX_LEN];
    int              a_len;
    int              b_len;
    logic            trunc_flag;
    logic            order_flag;

    edit_result_t expected_dist_q [$];

    int s_idle_pct;
    int r_idle_pct;
    int rx_hold_req;
    int rx_hold_left;
    int idle_cycles;
    int fail_count;
    int items_sent;
    int results_seen;
    int trunc_results;
    int order_results;

    levenshtein_edit_distance_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_ch          (s_ch),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_distance    (m_distance),
        .m_overflow    (m_overflow),
        .m_order_error (m_order_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_pair();
        for (int i = 0; i < MAX_LEN; i++) cost_col[i] = i + 1;
        a_len      = 0;
        b_len      = 0;
        trunc_flag = 1'b0;
        order_flag = 1'b0;
    endfunction

    function automatic bit edit_step(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                     output edit_result_t res);
        int diag;
        int left;
        int old_cost;
        int sub;
        int v;
        int d;
        res = '0;
        case (op)
            OP_FIRST: begin
                if (b_len != 0) begin
                    order_flag = 1'b1;
                end else if (a_len >= MAX_LEN) begin
                    trunc_flag = 1'b1;
                end else begin
                    a_chars[a_len] = ch;
                    a_len++;
                end
            end
            OP_SECOND: begin
                if (b_len >= MAX_LEN) begin
                    trunc_flag = 1'b1;
                end else begin
                    diag = b_len;
                    left = b_len + 1;
                    for (int y = 0; y < a_len; y++) begin
                        old_cost = cost_col[y];
                        sub = diag + ((a_chars[y] == ch) ? 0 : 1);
                        v = old_cost + 1;
                        if (left + 1 < v) v = left + 1;
                        if (sub < v) v = sub;
                        cost_col[y] = v;
                        left = v;
                        diag = old_cost;
                    end
                    b_len++;
                end
            end
            OP_FINISH: begin
                d = (a_len == 0) ? b_len : cost_col[a_len - 1];
                if (d > DIST_MAX) d = DIST_MAX;
                res.distance    = d[DIST_W-1:0];
                res.overflow    = trunc_flag;
                res.order_error = order_flag;
                clear_pair();
                return 1'b1;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [CH_W-1:0] pick_char(input bit wide);
        if (wide) return CH_W'($urandom_range(0, 255));
        return CH_W'(8'h61 + $urandom_range(0, 3));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 88) return $urandom_range(1, 10);
        if (r < 96) return $urandom_range(11, MAX_LEN);
        return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input bit typed, input edit_result_t typed_res);
        edit_result_t res;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_ch    <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (op != OP_RESERVED) items_sent++;
        if (edit_step(op, ch, res))
            expected_dist_q.insert(expected_dist_q.size(), typed ? typed_res : res);
    endtask

    task automatic run_pair(input int la, input int lb, input bit noisy);
        bit wide;
        int misplace;
        wide = ($urandom_range(0, 9) < 3);
        misplace = -1;
        if (noisy && lb > 0 && $urandom_range(0, 99) < 8) misplace = $urandom_range(1, lb);
        for (int i = 0; i < la; i++) begin
            if (noisy && $urandom_range(0, 99) < 4)
                send_item(OP_RESERVED, CH_W'($urandom_range(0, 255)), 1'b0, '0);
            send_item(OP_FIRST, pick_char(wide), 1'b0, '0);
        end
        for (int i = 0; i < lb; i++) begin
            if (noisy && $urandom_range(0, 99) < 4)
                send_item(OP_RESERVED, CH_W'($urandom_range(0, 255)), 1'b0, '0);
            send_item(OP_SECOND, pick_char(wide), 1'b0, '0);
            // first-string char out of order
            if (i + 1 == misplace) send_item(OP_FIRST, pick_char(wide), 1'b0, '0);
        end
        send_item(OP_FINISH, CH_W'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (expected_dist_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin : receiver
        edit_result_t want;
        if (m_valid && m_ready) begin
            if (expected_dist_q.size() == 0) begin
                $error("unexpected result transfer: distance %0d", m_distance);
                fail_count++;
            end else begin
                want = expected_dist_q.pop_front();
                results_seen++;
                if (want.overflow) trunc_results++;
                if (want.order_error) order_results++;
                if (m_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, m_distance);
                    fail_count++;
                end
                if (m_overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, m_overflow);
                    fail_count++;
                end
                if (m_order_error !== want.order_error) begin
                    $error("order_error: expected %0d, got %0d", want.order_error,
                           m_order_error);
                    fail_count++;
                end
            end
        end
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("levenshtein_edit_distance_unit test failed");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = OP_FIRST;
        s_ch         = '0;
        m_ready      = 1'b0;
        s_idle_pct   = 30;
        r_idle_pct   = 80;
        rx_hold_req  = 0;
        rx_hold_left = 0;
        idle_cycles  = 0;
        fail_count   = 0;
        items_sent   = 0;
        results_seen = 0;
        trunc_results = 0;
        order_results = 0;
        clear_pair();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_ROWS; r++)
            send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].res);

        for (int p = 0; p < 3; p++) begin
            s_idle_pct = (p == 0) ? 30 : (p == 1) ? 80 : 0;
            r_idle_pct = (p == 0) ? 80 : (p == 1) ? 30 : 0;
            if (p == 2) begin
                // long receiver hold-off while short pairs keep coming
                rx_hold_req = HOLD_CYCLES;
                repeat (6) run_pair(2, 2, 1'b0);
                s_valid <= 1'b0;
                wait_drained();
            end
            while (items_sent < (p + 1) * ITEM_TARGET / 3)
                run_pair(pick_len(), pick_len(), 1'b1);
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_dist_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_dist_q.size());
            fail_count += expected_dist_q.size();
        end

        $display("covered %0d input transfers and %0d checked distances", items_sent,
                 results_seen);
        $display("pairs with truncation: %0d, pairs with out-of-order chars: %0d",
                 trunc_results, order_results);
        if (fail_count == 0) begin
            $display("levenshtein_edit_distance_unit test passed");
        end else begin
            $display("levenshtein_edit_distance_unit test failed");
        end
        $finish;
    end

endmodule
